### hw/rtl/pee_pkg.sv
// Shared types and character constants for the prefix expression evaluator.
package pee_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OPC_ADD,
    OPC_SUB,
    OPC_MUL
  } opc_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_DEC,
    ALU_MLL,
    ALU_MLH,
    ALU_MHL
  } alu_cmd_e;

  typedef struct packed {
    alu_cmd_e   cmd;
    logic [3:0] digit;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIN,
    ST_ACT,
    ST_LOOP,
    ST_DATA,
    ST_MLH,
    ST_MHL,
    ST_PUSH,
    ST_NGRD,
    ST_NGWR,
    ST_SBRD1,
    ST_SBRD2,
    ST_SBWR,
    ST_EFIN,
    ST_ERD,
    ST_EOUT
  } state_e;

endpackage

### hw/rtl/prefix_expression_evaluator_core.sv
// Top level of the prefix expression evaluator: stacks, sequencer and output register.
//
//  Channel  Dir  Word                      Sideband
//  s_axis   in   tdata[7:0]  character     tlast = line_end
//  m_axis   out  tdata[63:0] value         tuser[0] = invalid
//
// A character runs IDLE, FIN, ACT; a line's last one adds EFIN, ERD, EOUT and a result.
// A ')' on '+' or '*' runs each operand through LOOP and DATA, for '*' also MLH, MHL
// (the 32x32 multiplier in pee_alu runs three passes per 64-bit product), then PUSH;
// '-' runs NGRD, NGWR or SBRD1 to SBWR. Every operand is read through one stack RAM read port.
// Reset clears state, acc_q, counters and flags; the stack RAMs need no clearing pass.
// The result sits in an output register, so the next word is taken while it waits.
module prefix_expression_evaluator_core #(
  parameter int unsigned OPERAND_DEPTH  = 64,
  parameter int unsigned OPERATOR_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [0:0]  m_axis_tuser    // [0] invalid
);
  import pee_pkg::*;

  localparam int unsigned CW   = $clog2(OPERAND_DEPTH + 1);
  localparam int unsigned IWD  = $clog2(OPERAND_DEPTH);
  localparam int unsigned PCW  = $clog2(OPERATOR_DEPTH + 1);
  localparam int unsigned IWP  = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
  localparam int unsigned OEW  = 2 + CW;

  state_e state_q, state_d;

  logic [7:0]        ch_q, ch_d;
  logic              last_q, last_d;
  logic [63:0]       acc_q, acc_d;
  logic              in_num_q, in_num_d;
  logic              expect_q, expect_d;
  logic              err_q, err_d;
  logic [CW-1:0]     opnd_cnt_q, opnd_cnt_d;
  logic [PCW-1:0]    op_cnt_q, op_cnt_d;
  opc_e              top_code_q, top_code_d;
  logic [CW-1:0]     top_argc_q, top_argc_d;
  opc_e              cl_code_q, cl_code_d;
  logic [CW-1:0]     k_q, k_d;
  logic [63:0]       res_q, res_d;
  logic [63:0]       prod_q, prod_d;
  logic              reload_q, reload_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       out_value_q, out_value_d;
  logic              out_inv_q, out_inv_d;

  logic [63:0]       opnd_mem [OPERAND_DEPTH];
  logic [63:0]       opnd_rd_q;
  logic              opnd_we, opnd_re;
  logic [IWD-1:0]    opnd_waddr, opnd_raddr;
  logic [63:0]       opnd_wdata;

  logic [OEW-1:0]    op_mem [OPERATOR_DEPTH];
  logic [OEW-1:0]    op_rd_q;
  logic              op_we, op_re;
  logic [IWP-1:0]    op_waddr, op_raddr;
  logic [OEW-1:0]    op_wdata;

  alu_req_t          alu_req;
  logic [63:0]       alu_a, alu_b, alu_c, alu_y;

  logic              is_digit, is_open, is_close, is_opch;
  opc_e              ch_code;
  logic              opnd_full, op_full, op_empty, fin_en, out_free;
  logic [CW-1:0]     opnd_cnt_m1, opnd_cnt_m2;
  logic [PCW-1:0]    op_cnt_m1, op_cnt_m2;
  state_e            st_after;

  pee_alu u_alu (
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .y_o   (alu_y)
  );

  always_comb begin
    is_digit    = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
    is_open     = (ch_q == CH_OPEN);
    is_close    = (ch_q == CH_CLOSE);
    is_opch     = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) || (ch_q == CH_STAR);
    priority if (ch_q == CH_PLUS) ch_code = OPC_ADD;
    else if (ch_q == CH_MINUS)    ch_code = OPC_SUB;
    else                          ch_code = OPC_MUL;
    opnd_full   = (opnd_cnt_q == CW'(OPERAND_DEPTH));
    op_full     = (op_cnt_q == PCW'(OPERATOR_DEPTH));
    op_empty    = (op_cnt_q == '0);
    opnd_cnt_m1 = opnd_cnt_q - CW'(1);
    opnd_cnt_m2 = opnd_cnt_q - CW'(2);
    op_cnt_m1   = op_cnt_q - PCW'(1);
    op_cnt_m2   = op_cnt_q - PCW'(2);
    out_free    = !out_valid_q || m_axis_tready;
    st_after    = last_q ? ST_EFIN : ST_IDLE;
    // A digit run ends at the first non-digit, and at the end of the line.
    fin_en      = ((state_q == ST_FIN) && !err_q && !expect_q && in_num_q && !is_digit) ||
                  ((state_q == ST_EFIN) && !err_q && in_num_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_FIN;
      ST_FIN:   state_d = ST_ACT;
      ST_ACT: begin
        state_d = st_after;
        if (!err_q && !expect_q && is_close && !op_empty && !(top_argc_q > opnd_cnt_q)) begin
          if (top_code_q == OPC_SUB) begin
            if (top_argc_q == CW'(1))      state_d = ST_NGRD;
            else if (top_argc_q == CW'(2)) state_d = ST_SBRD1;
          end else begin
            state_d = ST_LOOP;
          end
        end
      end
      ST_LOOP:  state_d = (k_q == '0) ? ST_PUSH : ST_DATA;
      ST_DATA:  state_d = (cl_code_q == OPC_MUL) ? ST_MLH : ST_LOOP;
      ST_MLH:   state_d = ST_MHL;
      ST_MHL:   state_d = ST_LOOP;
      ST_PUSH:  state_d = st_after;
      ST_NGRD:  state_d = ST_NGWR;
      ST_NGWR:  state_d = st_after;
      ST_SBRD1: state_d = ST_SBRD2;
      ST_SBRD2: state_d = ST_SBWR;
      ST_SBWR:  state_d = st_after;
      ST_EFIN:  state_d = ST_ERD;
      ST_ERD:   state_d = ST_EOUT;
      ST_EOUT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    ch_d        = ch_q;
    last_d      = last_q;
    acc_d       = acc_q;
    in_num_d    = in_num_q;
    expect_d    = expect_q;
    err_d       = err_q;
    opnd_cnt_d  = opnd_cnt_q;
    op_cnt_d    = op_cnt_q;
    top_code_d  = top_code_q;
    top_argc_d  = top_argc_q;
    cl_code_d   = cl_code_q;
    k_d         = k_q;
    res_d       = res_q;
    prod_d      = prod_q;
    reload_d    = 1'b0;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_inv_d   = out_inv_q;

    opnd_we     = 1'b0;
    opnd_re     = 1'b0;
    opnd_waddr  = opnd_cnt_q[IWD-1:0];
    opnd_raddr  = opnd_cnt_m1[IWD-1:0];
    opnd_wdata  = res_q;
    op_we       = 1'b0;
    op_re       = 1'b0;
    op_waddr    = op_cnt_m1[IWP-1:0];
    op_raddr    = op_cnt_m2[IWP-1:0];
    op_wdata    = {top_code_q, top_argc_q};

    alu_req.cmd   = ALU_ADD;
    alu_req.digit = ch_q[3:0];
    alu_a         = res_q;
    alu_b         = opnd_rd_q;
    alu_c         = prod_q;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    // The operator below a popped one comes back from RAM in the cycle after the pop.
    if (reload_q) begin
      top_code_d = opc_e'(op_rd_q[OEW-1 -: 2]);
      top_argc_d = op_rd_q[CW-1:0];
    end

    if (fin_en) begin
      in_num_d = 1'b0;
      if (op_empty || opnd_full) begin
        err_d = 1'b1;
      end else begin
        opnd_we    = 1'b1;
        opnd_wdata = acc_q;
        opnd_cnt_d = opnd_cnt_q + CW'(1);
        top_argc_d = top_argc_q + CW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ch_d   = s_axis_tdata;
          last_d = s_axis_tlast;
        end
      end
      ST_ACT: begin
        if (!err_q) begin
          if (expect_q) begin
            expect_d = 1'b0;
            if (!is_opch || op_full) begin
              err_d = 1'b1;
            end else begin
              op_we      = !op_empty;
              top_code_d = ch_code;
              top_argc_d = '0;
              op_cnt_d   = op_cnt_q + PCW'(1);
            end
          end else if (is_digit) begin
            alu_req.cmd = ALU_DEC;
            alu_a       = acc_q;
            acc_d       = in_num_q ? alu_y : {60'd0, ch_q[3:0]};
            in_num_d    = 1'b1;
          end else if (is_open) begin
            expect_d = 1'b1;
          end else if (is_close) begin
            if (op_empty) begin
              err_d = 1'b1;
            end else begin
              op_cnt_d  = op_cnt_m1;
              cl_code_d = top_code_q;
              k_d       = top_argc_q;
              if (op_cnt_q > PCW'(1)) begin
                op_re    = 1'b1;
                reload_d = 1'b1;
              end
              if (top_argc_q > opnd_cnt_q) begin
                err_d = 1'b1;
              end else if (top_code_q == OPC_SUB) begin
                if (top_argc_q != CW'(1) && top_argc_q != CW'(2)) err_d = 1'b1;
              end else begin
                res_d = (top_code_q == OPC_MUL) ? 64'd1 : 64'd0;
              end
            end
          end
        end
      end
      ST_LOOP: begin
        if (k_q != '0) begin
          opnd_re    = 1'b1;
          opnd_cnt_d = opnd_cnt_m1;
          k_d        = k_q - CW'(1);
        end
      end
      ST_DATA: begin
        if (cl_code_q == OPC_MUL) begin
          alu_req.cmd = ALU_MLL;
          prod_d      = alu_y;
        end else begin
          res_d = alu_y;
        end
      end
      ST_MLH: begin
        alu_req.cmd = ALU_MLH;
        prod_d      = alu_y;
      end
      ST_MHL: begin
        alu_req.cmd = ALU_MHL;
        res_d       = alu_y;
      end
      ST_PUSH: begin
        if (opnd_full) begin
          err_d = 1'b1;
        end else begin
          opnd_we    = 1'b1;
          opnd_cnt_d = opnd_cnt_q + CW'(1);
          if (!op_empty) top_argc_d = top_argc_q + CW'(1);
        end
      end
      ST_NGRD:  opnd_re = 1'b1;
      ST_NGWR: begin
        alu_req.cmd = ALU_SUB;
        alu_a       = '0;
        opnd_we     = 1'b1;
        opnd_waddr  = opnd_cnt_m1[IWD-1:0];
        opnd_wdata  = alu_y;
        if (!op_empty) top_argc_d = top_argc_q + CW'(1);
      end
      ST_SBRD1: opnd_re = 1'b1;
      ST_SBRD2: begin
        res_d      = opnd_rd_q;
        opnd_re    = 1'b1;
        opnd_raddr = opnd_cnt_m2[IWD-1:0];
      end
      ST_SBWR: begin
        alu_req.cmd = ALU_SUB;
        alu_a       = opnd_rd_q;
        alu_b       = res_q;
        opnd_we     = 1'b1;
        opnd_waddr  = opnd_cnt_m2[IWD-1:0];
        opnd_wdata  = alu_y;
        opnd_cnt_d  = opnd_cnt_m1;
        if (!op_empty) top_argc_d = top_argc_q + CW'(1);
      end
      ST_ERD: begin
        err_d   = err_q || expect_q || (opnd_cnt_q == '0);
        opnd_re = 1'b1;
      end
      ST_EOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = err_q ? 64'd0 : opnd_rd_q;
          out_inv_d   = err_q;
          acc_d       = '0;
          in_num_d    = 1'b0;
          expect_d    = 1'b0;
          err_d       = 1'b0;
          opnd_cnt_d  = '0;
          op_cnt_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      in_num_q    <= 1'b0;
      expect_q    <= 1'b0;
      err_q       <= 1'b0;
      opnd_cnt_q  <= '0;
      op_cnt_q    <= '0;
      reload_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      in_num_q    <= in_num_d;
      expect_q    <= expect_d;
      err_q       <= err_d;
      opnd_cnt_q  <= opnd_cnt_d;
      op_cnt_q    <= op_cnt_d;
      reload_q    <= reload_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    last_q      <= last_d;
    top_code_q  <= top_code_d;
    top_argc_q  <= top_argc_d;
    cl_code_q   <= cl_code_d;
    k_q         <= k_d;
    res_q       <= res_d;
    prod_q      <= prod_d;
    out_value_q <= out_value_d;
    out_inv_q   <= out_inv_d;
  end

  always_ff @(posedge clk_i) begin
    if (opnd_we) opnd_mem[opnd_waddr] <= opnd_wdata;
    if (opnd_re) opnd_rd_q <= opnd_mem[opnd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (op_we) op_mem[op_waddr] <= op_wdata;
    if (op_re) op_rd_q <= op_mem[op_raddr];
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_value_q;
  assign m_axis_tuser[0] = out_inv_q;

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
    else $error("invalid result carries a nonzero value");

  a_opnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opnd_cnt_q <= CW'(OPERAND_DEPTH))
    else $error("operand count beyond stack depth");

  a_op_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_cnt_q <= PCW'(OPERATOR_DEPTH))
    else $error("operator count beyond stack depth");

  a_reload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload_q |-> (op_cnt_q != '0))
    else $error("operator reload with an empty operator stack");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EOUT && out_free) |=> (opnd_cnt_q == '0 && op_cnt_q == '0 && !err_q))
    else $error("state not cleared after a line result");

endmodule

### hw/rtl/pee_alu.sv
// Shared arithmetic unit: add, subtract, decimal step and one 32x32 multiplier.
module pee_alu (
  input  pee_pkg::alu_req_t req_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  input  logic [63:0]       c_i,
  output logic [63:0]       y_o
);
  import pee_pkg::*;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;

  always_comb begin
    mul_x = (req_i.cmd == ALU_MHL) ? a_i[63:32] : a_i[31:0];
    mul_y = (req_i.cmd == ALU_MLH) ? b_i[63:32] : b_i[31:0];
    prod  = {32'd0, mul_x} * {32'd0, mul_y};
  end

  // The cross partial products only reach the upper word of a wrapped 64-bit product.
  always_comb begin
    unique case (req_i.cmd)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      ALU_DEC: y_o = {a_i[60:0], 3'd0} + {a_i[62:0], 1'b0} + {60'd0, req_i.digit};
      ALU_MLL: y_o = prod;
      ALU_MLH,
      ALU_MHL: y_o = {c_i[63:32] + prod[31:0], c_i[31:0]};
      default: y_o = '0;
    endcase
  end

endmodule

### tb/prefix_expression_evaluator_core_tb.sv
// Self-checking testbench for the prefix expression evaluator core.
module prefix_expression_evaluator_core_tb;
  import pee_pkg::*;

  localparam int unsigned OPND_DEPTH     = 64;
  localparam int unsigned OPTR_DEPTH     = 64;
  localparam int unsigned RANDOM_ITEMS   = 360;
  localparam int unsigned NO_IDLE_FROM   = 60;
  localparam int unsigned NO_IDLE_TO     = 220;
  localparam int unsigned PAUSE_AT       = 280;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_GAP      = 8;
  localparam int unsigned END_GAP        = 300;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [63:0] value;
    logic        invalid;
    logic [31:0] line_no;
  } line_result_t;

  typedef struct {
    string       text;
    bit          known;
    logic [63:0] value;
    bit          invalid;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'd0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_data;
  logic [0:0]  m_user;

  prefix_expression_evaluator_core #(
    .OPERAND_DEPTH (OPND_DEPTH),
    .OPERATOR_DEPTH(OPTR_DEPTH)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tlast (s_last),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shared run state.
  line_result_t pending_line_results[$];
  logic [7:0]   line_buf[$];
  dir_row_t     dir_rows[$];
  int unsigned  idle_pct = 24;
  bit           rx_hold_req = 1'b0;
  int unsigned  chars_sent = 0;
  int unsigned  lines_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  invalid_seen = 0;
  int unsigned  mismatch_count = 0;

  // Evaluator state mirrored by the predictor.
  logic [63:0] opnd_mem [OPND_DEPTH];
  int unsigned opnd_cnt;
  opc_e        optr_code [OPTR_DEPTH];
  int unsigned optr_argc [OPTR_DEPTH];
  int unsigned optr_cnt;
  logic [63:0] num_acc;
  bit          num_active;
  bit          want_op;
  bit          err_flag;

  function automatic void eval_clear();
    opnd_cnt   = 0;
    optr_cnt   = 0;
    num_acc    = 64'd0;
    num_active = 1'b0;
    want_op    = 1'b0;
    err_flag   = 1'b0;
  endfunction

  function automatic void eval_push(logic [63:0] v);
    if (opnd_cnt >= OPND_DEPTH) begin
      err_flag = 1'b1;
      return;
    end
    opnd_mem[opnd_cnt] = v;
    opnd_cnt++;
  endfunction

  function automatic void eval_end_number();
    num_active = 1'b0;
    if (optr_cnt == 0) begin
      err_flag = 1'b1;
      return;
    end
    eval_push(num_acc);
    if (!err_flag) optr_argc[optr_cnt-1]++;
  endfunction

  function automatic void eval_close();
    opc_e        code;
    int unsigned argc;
    logic [63:0] acc;
    if (optr_cnt == 0) begin
      err_flag = 1'b1;
      return;
    end
    optr_cnt--;
    code = optr_code[optr_cnt];
    argc = optr_argc[optr_cnt];
    if (argc > opnd_cnt) begin
      err_flag = 1'b1;
      return;
    end
    if (code == OPC_SUB) begin
      if (argc == 1) begin
        opnd_mem[opnd_cnt-1] = 64'd0 - opnd_mem[opnd_cnt-1];
      end else if (argc == 2) begin
        opnd_mem[opnd_cnt-2] = opnd_mem[opnd_cnt-2] - opnd_mem[opnd_cnt-1];
        opnd_cnt--;
      end else begin
        err_flag = 1'b1;
        return;
      end
    end else begin
      acc = (code == OPC_MUL) ? 64'd1 : 64'd0;
      repeat (argc) begin
        opnd_cnt--;
        if (code == OPC_MUL) acc = acc * opnd_mem[opnd_cnt];
        else acc = acc + opnd_mem[opnd_cnt];
      end
      eval_push(acc);
      if (err_flag) return;
    end
    if (optr_cnt > 0) optr_argc[optr_cnt-1]++;
  endfunction

  function automatic void eval_take(logic [7:0] ch);
    bit digit;
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (want_op) begin
      want_op = 1'b0;
      if (ch != CH_PLUS && ch != CH_MINUS && ch != CH_STAR) begin
        err_flag = 1'b1;
        return;
      end
      if (optr_cnt >= OPTR_DEPTH) begin
        err_flag = 1'b1;
        return;
      end
      optr_code[optr_cnt] = (ch == CH_PLUS) ? OPC_ADD : (ch == CH_MINUS) ? OPC_SUB : OPC_MUL;
      optr_argc[optr_cnt] = 0;
      optr_cnt++;
      return;
    end
    if (num_active && !digit) begin
      eval_end_number();
      if (err_flag) return;
    end
    if (digit) begin
      // Digits 0 to 9 sit in the low nibble of their ASCII codes.
      if (num_active) begin
        num_acc = num_acc * 64'd10 + {60'd0, ch[3:0]};
      end else begin
        num_acc    = {60'd0, ch[3:0]};
        num_active = 1'b1;
      end
    end else if (ch == CH_OPEN) begin
      want_op = 1'b1;
    end else if (ch == CH_CLOSE) begin
      eval_close();
    end
  endfunction

  function automatic void eval_line_char(input logic [7:0] ch, input bit last,
                                         output bit has_result, output line_result_t res);
    has_result = 1'b0;
    res = '0;
    if (!err_flag) eval_take(ch);
    if (!last) return;
    if (!err_flag && num_active) eval_end_number();
    if (want_op) err_flag = 1'b1;
    if (!err_flag && opnd_cnt == 0) err_flag = 1'b1;
    has_result  = 1'b1;
    res.invalid = err_flag;
    res.value   = err_flag ? 64'd0 : opnd_mem[opnd_cnt-1];
    eval_clear();
  endfunction

  // Line builders: the put_ functions append to line_buf, drop_last removes its last byte.
  function automatic void put_byte(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  function automatic void drop_last();
    line_buf.delete(line_buf.size() - 1);
  endfunction

  function automatic void put_str(string t);
    for (int i = 0; i < t.len(); i++) put_byte(t[i]);
  endfunction

  function automatic string repeat_str(string t, int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, t};
    return s;
  endfunction

  function automatic void put_number();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    n = (r < 70) ? $urandom_range(1, 2) : (r < 92) ? $urandom_range(3, 6) :
        $urandom_range(15, 22);
    repeat (n) put_byte(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void put_sep();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 70) begin
      put_str(" ");
    end else if (r < 85) begin
      put_str("  ");
    end else begin
      // Any byte that neither opens, closes nor continues a number.
      do b = 8'($urandom_range(255));
      while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_OPEN || b == CH_CLOSE);
      put_byte(b);
    end
  endfunction

  function automatic logic [7:0] put_open();
    logic [7:0] op;
    case ($urandom_range(2))
      0:       op = CH_PLUS;
      1:       op = CH_MINUS;
      default: op = CH_STAR;
    endcase
    put_byte(CH_OPEN);
    put_byte(op);
    return op;
  endfunction

  function automatic int unsigned pick_argc(logic [7:0] op, int unsigned max_args);
    if (op == CH_MINUS)
      return ($urandom_range(9) != 0) ? $urandom_range(1, 2) : 3 * $urandom_range(1);
    return $urandom_range(max_args);
  endfunction

  function automatic logic [7:0] pick_special();
    string specials;
    specials = "()+-* 0123456789";
    if ($urandom_range(1) == 0) return specials[$urandom_range(specials.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Builds a well-formed expression without recursion: one argument budget per open level.
  function automatic void build_expr(int unsigned max_depth, int unsigned max_args);
    int unsigned open_args[$];
    logic [7:0]  op;
    op = put_open();
    open_args.insert(open_args.size(), pick_argc(op, max_args));
    while (open_args.size() > 0) begin
      if (open_args[open_args.size()-1] == 0) begin
        put_byte(CH_CLOSE);
        open_args.delete(open_args.size() - 1);
      end else begin
        open_args[open_args.size()-1] -= 1;
        put_sep();
        if (open_args.size() < max_depth && $urandom_range(2) == 0) begin
          op = put_open();
          open_args.insert(open_args.size(), pick_argc(op, max_args));
        end else begin
          put_number();
        end
      end
    end
  endfunction

  function automatic void gen_random_line();
    int unsigned r;
    int unsigned idx;
    line_buf.delete();
    r = $urandom_range(99);
    if (r < 75) begin
      if ($urandom_range(9) == 0) put_str(" ");
      if (r < 4) build_expr(8, 8);
      else build_expr($urandom_range(1, 4), 4);
      // Now and then leave the outermost operator open.
      if ($urandom_range(19) == 0) drop_last();
    end else if (r < 87) begin
      build_expr($urandom_range(1, 3), 3);
      idx = $urandom_range(line_buf.size() - 1);
      case ($urandom_range(2))
        0: while (line_buf.size() > idx + 1) drop_last();
        1: line_buf[idx] = pick_special();
        default: line_buf.insert(idx, pick_special());
      endcase
    end else if (r < 96) begin
      repeat ($urandom_range(1, 10)) put_byte(pick_special());
    end else begin
      if ($urandom_range(1) == 0) put_number();
      else put_str(repeat_str(" ", $urandom_range(1, 3)));
    end
  endfunction

  task automatic send_char(input logic [7:0] ch, input bit last, input bit known,
                           input logic [63:0] known_value, input bit known_invalid);
    bit           has_result;
    line_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    chars_sent++;
    eval_line_char(ch, last, has_result, res);
    if (has_result) begin
      if (known) begin
        res.value   = known_value;
        res.invalid = known_invalid;
      end
      res.line_no = lines_sent;
      pending_line_results.insert(pending_line_results.size(), res);
      lines_sent++;
    end
  endtask

  task automatic send_line(input bit known, input logic [63:0] known_value,
                           input bit known_invalid);
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1, known, known_value, known_invalid);
  endtask

  task automatic wait_drain();
    s_valid <= 1'b0;
    while (pending_line_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  function automatic void add_row(string text, bit known, logic [63:0] value, bit invalid);
    dir_row_t row;
    row.text    = text;
    row.known   = known;
    row.value   = value;
    row.invalid = invalid;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin : receiver
    bit held_once;
    held_once = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req && !held_once) begin
        held_once = 1'b1;
        m_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      m_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && m_valid && m_ready) begin
      results_checked++;
      if (m_user[0]) invalid_seen++;
      if (pending_line_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result: value %h invalid %0b", m_data, m_user[0]);
      end else begin
        want = pending_line_results.pop_front();
        if (m_data !== want.value || m_user[0] !== want.invalid) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch on line %0d: expected value %h invalid %0b, got value %h invalid %0b",
                     want.line_no, want.value, want.invalid, m_data, m_user[0]);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 20);
    $display("Run timed out with %0d results outstanding", pending_line_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_chars;
    bit          paused_once;
    rand_chars  = 0;
    paused_once = 1'b0;
    eval_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    add_row("(+ 1 2)", 1, 64'd3, 0);
    add_row("(+)", 1, 64'd0, 0);
    add_row("(*)", 1, 64'd1, 0);
    add_row("(- 5)", 1, 64'hFFFF_FFFF_FFFF_FFFB, 0);
    add_row("(- 9 4)", 1, 64'd5, 0);
    add_row("(* 3 (- 2) 7)", 1, 64'hFFFF_FFFF_FFFF_FFD6, 0);
    add_row("(+ 18446744073709551615)", 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_row("(+ 9223372036854775807 1)", 1, 64'h8000_0000_0000_0000, 0);
    add_row("(* 4294967296 4294967296)", 1, 64'd0, 0);
    add_row("(+ 99999999999999999999)", 0, 64'd0, 0);
    add_row("(* 2\3773)", 1, 64'd6, 0);
    add_row("(+ 4 5", 1, 64'd5, 0);
    add_row("(+ 4 (* 2 3)", 0, 64'd0, 0);
    add_row("(+ 1 2)x", 1, 64'd3, 0);
    add_row("(-)", 1, 64'd0, 1);
    add_row("(- 1 2 3)", 1, 64'd0, 1);
    add_row("(/ 1)", 1, 64'd0, 1);
    add_row("( + 1)", 1, 64'd0, 1);
    add_row(")", 1, 64'd0, 1);
    add_row("7", 1, 64'd0, 1);
    add_row("(+ 1 2) 5", 1, 64'd0, 1);
    add_row("(", 1, 64'd0, 1);
    add_row("(+ 1 (", 1, 64'd0, 1);
    add_row(" ", 1, 64'd0, 1);
    add_row("(+) ) 5", 1, 64'd0, 1);
    // Full stacks: exactly at depth, and one push beyond it.
    add_row({"(+", repeat_str(" 1", OPND_DEPTH), ")"}, 1, 64'(OPND_DEPTH), 0);
    add_row({"(+", repeat_str(" 1", OPND_DEPTH + 1), ")"}, 1, 64'd0, 1);
    add_row({"(*", repeat_str(" 3", OPND_DEPTH), ")"}, 0, 64'd0, 0);
    add_row({repeat_str("(+", OPTR_DEPTH), " 3", repeat_str(")", OPTR_DEPTH)}, 1, 64'd3, 0);
    add_row({repeat_str("(+", OPTR_DEPTH + 1), " 3"}, 1, 64'd0, 1);

    foreach (dir_rows[r]) begin
      line_buf.delete();
      put_str(dir_rows[r].text);
      send_line(dir_rows[r].known, dir_rows[r].value, dir_rows[r].invalid);
    end
    wait_drain();

    // The receiver stalls for a long stretch while lines keep coming.
    rx_hold_req = 1'b1;
    while (rand_chars < RANDOM_ITEMS) begin
      idle_pct = (rand_chars >= NO_IDLE_FROM && rand_chars < NO_IDLE_TO) ? 0 : 24;
      if (!paused_once && rand_chars >= PAUSE_AT) begin
        paused_once = 1'b1;
        wait_drain();
      end
      gen_random_line();
      rand_chars += line_buf.size();
      send_line(0, 64'd0, 0);
    end
    s_valid <= 1'b0;

    while (pending_line_results.size() != 0) @(posedge clk);
    repeat (END_GAP) @(posedge clk);

    $display("Sent %0d characters in %0d lines, directed and random, with stalls on both sides.",
             chars_sent, lines_sent);
    $display("Checked %0d results, %0d of them flagged invalid; %0d mismatches.",
             results_checked, invalid_seen, mismatch_count);
    if (mismatch_count == 0 && pending_line_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pee_pkg.sv
hw/rtl/pee_alu.sv
hw/rtl/prefix_expression_evaluator_core.sv
tb/prefix_expression_evaluator_core_tb.sv
